// ----- rtl/mpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO package
// Sizes, register indexes, action and status codes, and channel payload types.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int MAX_LEVELS = 8;
	localparam int CAPACITY   = 16;

	localparam int ID_W      = 8;
	localparam int LEVEL_W   = 3;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 5;
	localparam int LVL_CFG_W = 4;
	localparam int CAP_CFG_W = 5;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 2'd1;

	localparam logic [LVL_CFG_W-1:0] LEVELS_RESET   = 4'd8;
	localparam logic [CAP_CFG_W-1:0] CAPACITY_RESET = 5'd16;

	// actions
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LEVEL = 2'd3;

	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    item_id;
		logic [LEVEL_W-1:0] level;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0]     served_id;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    waiting_total;
	} out_t;

endpackage

// ----- rtl/multilevel_priority_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO
// Strict-priority queue of ids over a shared linked slot pool with a free list.
// ----------------------------------------------------------------------------
// Pipeline: a transaction is held in the input register, its result in the result register.
// Throughput: one transaction per cycle while the result channel is not stalled;
//   the queue state is read and updated between the input register and the result register.
// Reset: asynchronous, active low. Clears all levels, chains the free list in
//   slot order and restores levels_in_use to 8 and capacity_limit to 16.
module multilevel_priority_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mpq_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mpq_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpq_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int NL = mpq_pkg::MAX_LEVELS;
	localparam int NS = mpq_pkg::CAPACITY;

	// configuration
	logic [mpq_pkg::LVL_CFG_W-1:0] levels_q;
	logic [mpq_pkg::CAP_CFG_W-1:0] cap_q;

	// queue state
	logic [mpq_pkg::ID_W-1:0]    ids_q    [NS];
	logic [mpq_pkg::SLOT_W-1:0]  links_q  [NS];
	logic [mpq_pkg::SLOT_W-1:0]  heads_q  [NL];
	logic [mpq_pkg::SLOT_W-1:0]  tails_q  [NL];
	logic [mpq_pkg::CNT_W-1:0]   counts_q [NL];
	logic [mpq_pkg::SLOT_W-1:0]  free_head_q;
	logic [mpq_pkg::CNT_W-1:0]   total_q;

	// pipeline
	logic          valid_s1;
	mpq_pkg::in_t  item_s1;
	logic          out_valid_q;
	mpq_pkg::out_t out_q;

	logic advance;

	logic [mpq_pkg::LVL_CFG_W-1:0] eff_levels;
	logic [mpq_pkg::CAP_CFG_W-1:0] eff_cap;
	logic                          is_enq;
	logic                          lvl_bad;
	logic                          full;
	logic                          enq_ok;
	logic                          deq_ok;
	logic                          found;
	logic [mpq_pkg::LEVEL_W-1:0]   deq_lvl;
	logic [mpq_pkg::SLOT_W-1:0]    deq_slot;
	logic [mpq_pkg::SLOT_W-1:0]    link_rd;
	logic [mpq_pkg::LEVEL_W-1:0]   enq_lvl;
	mpq_pkg::out_t                 result;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		eff_levels = (levels_q > mpq_pkg::LVL_CFG_W'(NL)) ? mpq_pkg::LVL_CFG_W'(NL) : levels_q;
		eff_cap    = (cap_q > mpq_pkg::CAP_CFG_W'(NS)) ? mpq_pkg::CAP_CFG_W'(NS) : cap_q;
		is_enq     = (item_s1.action == mpq_pkg::ACT_ENQUEUE);
		enq_lvl    = item_s1.level;
		lvl_bad    = ({1'b0, enq_lvl} >= eff_levels);
		full       = (total_q >= eff_cap);
		enq_ok     = is_enq && !lvl_bad && !full;

		// lowest-numbered non-empty level in use
		found   = 1'b0;
		deq_lvl = '0;
		for (int i = NL - 1; i >= 0; i--) begin
			if ((counts_q[i] != '0) && (mpq_pkg::LVL_CFG_W'(i) < eff_levels)) begin
				found   = 1'b1;
				deq_lvl = mpq_pkg::LEVEL_W'(i);
			end
		end
		deq_ok   = !is_enq && found;
		deq_slot = heads_q[deq_lvl];
		link_rd  = links_q[is_enq ? free_head_q : deq_slot];

		result.served_id     = '0;
		result.status        = mpq_pkg::ST_OK;
		result.waiting_total = total_q;
		if (is_enq) begin
			if (lvl_bad) begin
				result.status = mpq_pkg::ST_LEVEL;
			end else if (full) begin
				result.status = mpq_pkg::ST_FULL;
			end else begin
				result.waiting_total = total_q + 1'b1;
			end
		end else begin
			if (found) begin
				result.served_id     = ids_q[deq_slot];
				result.waiting_total = total_q - 1'b1;
			end else begin
				result.status = mpq_pkg::ST_EMPTY;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= mpq_pkg::LEVELS_RESET;
			cap_q    <= mpq_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mpq_pkg::REG_LEVELS_IN_USE:  levels_q <= cfg_data[mpq_pkg::LVL_CFG_W-1:0];
				mpq_pkg::REG_CAPACITY_LIMIT: cap_q    <= cfg_data[mpq_pkg::CAP_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// input register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	// control state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				links_q[i] <= mpq_pkg::SLOT_W'((i + 1) % NS);
			end
			for (int i = 0; i < NL; i++) begin
				counts_q[i] <= '0;
			end
			free_head_q <= '0;
			total_q     <= '0;
		end else if (advance) begin
			if (enq_ok) begin
				free_head_q       <= link_rd;
				counts_q[enq_lvl] <= counts_q[enq_lvl] + 1'b1;
				total_q           <= total_q + 1'b1;
				if (counts_q[enq_lvl] != '0) begin
					links_q[tails_q[enq_lvl]] <= free_head_q;
				end
			end else if (deq_ok) begin
				counts_q[deq_lvl] <= counts_q[deq_lvl] - 1'b1;
				total_q           <= total_q - 1'b1;
				links_q[deq_slot] <= free_head_q;
				free_head_q       <= deq_slot;
			end
		end
	end

	// payload state, meaningful only once written
	always_ff @(posedge clk) begin
		if (advance) begin
			if (enq_ok) begin
				ids_q[free_head_q] <= item_s1.item_id;
				tails_q[enq_lvl]   <= free_head_q;
				if (counts_q[enq_lvl] == '0) begin
					heads_q[enq_lvl] <= free_head_q;
				end
			end else if (deq_ok) begin
				heads_q[deq_lvl] <= link_rd;
			end
		end
	end

endmodule

// ----- rtl/mpq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO checker
// Port-level properties of the result channel and configuration port.
// ----------------------------------------------------------------------------
module mpq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input mpq_pkg::out_t out_data,
	input logic          cfg_valid,
	input logic          cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a failed transaction returns no id
	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != mpq_pkg::ST_OK) |-> out_data.served_id == '0)
		else $error("id returned on failed transaction");

	// pool never holds more than its size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.waiting_total <= mpq_pkg::CNT_W'(mpq_pkg::CAPACITY))
		else $error("waiting total above capacity");

	// a failed transaction leaves the total as the previous result showed it
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && (out_data.status != mpq_pkg::ST_OK) |->
		out_data.waiting_total == $past(out_data.waiting_total))
		else $error("waiting total changed on failed transaction");

	// configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind multilevel_priority_fifo mpq_checker u_mpq_checker (.*);
